/* src/acls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer package
// Shared constants, job and result types, and the command string ROM.
// ----------------------------------------------------------------------------
package acls_pkg;

  localparam int LINE_SPAN_DEFAULT = 64;
  localparam int HEAD_DEPTH        = 5;
  localparam int HEAD_IDX_W        = 3;
  localparam int CMD_ROWS          = 7;
  localparam int ROW_W             = 3;
  localparam int IDX_W             = 6;
  localparam int ROM_BITS          = 344;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = 2;

  localparam logic [7:0] BYTE_SKIP = 8'hE1;
  localparam logic [7:0] BYTE_CR   = 8'h0D;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CMD,
    ACT_ROT_RIGHT,
    ACT_ROT_LEFT
  } acls_act_t;

  typedef struct packed {
    logic             echo;
    logic [7:0]       echo_byte;
    acls_act_t        act;
    logic [ROW_W-1:0] row;
  } acls_job_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       rotate_right;
    logic       last;
  } acls_result_t;

  function automatic logic [IDX_W-1:0] cmd_len(input logic [ROW_W-1:0] row);
    case (row)
      3'd0:    cmd_len = 6'd4;
      3'd1:    cmd_len = 6'd13;
      3'd2:    cmd_len = 6'd10;
      3'd3:    cmd_len = 6'd43;
      3'd4:    cmd_len = 6'd39;
      3'd5:    cmd_len = 6'd15;
      3'd6:    cmd_len = 6'd21;
      default: cmd_len = 6'd0;
    endcase
  endfunction

  // Strings are stored right-aligned, first character in the highest byte.
  function automatic logic [7:0] cmd_byte(input logic [ROW_W-1:0] row,
                                          input logic [IDX_W-1:0] idx);
    logic [ROM_BITS-1:0] text;
    logic [IDX_W-1:0]    pos;
    case (row)
      3'd0:    text = ROM_BITS'("AT\r\n");
      3'd1:    text = ROM_BITS'("AT+CWMODE=3\r\n");
      3'd2:    text = ROM_BITS'("AT+CWQAP\r\n");
      3'd3:    text = ROM_BITS'({80'h41542B43574A41503D22, 80'h7373656D656E6B6F6666,
                                 80'h2D70726976617465222C, 80'h2273656D656E6B6F6666,
                                 24'h220D0A});
      3'd4:    text = ROM_BITS'({80'h41542B43495053544152, 80'h543D22544350222C2231,
                                 80'h39322E3136382E313030, 72'h2E3130222C38300D0A});
      3'd5:    text = ROM_BITS'("AT+CIPSEND=21\r\n");
      3'd6:    text = ROM_BITS'("GET /state HTTP/1.1\r\n");
      default: text = '0;
    endcase
    pos      = cmd_len(row) - 6'd1 - idx;
    cmd_byte = text[{pos, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

/* src/acls_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface acls_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface acls_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       rotate_right;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output rotate_right,
                  output last, input ready);
  modport sink (input valid, input kind, input tx_byte, input rotate_right,
                input last, output ready);
endinterface
`default_nettype wire

/* src/at_command_link_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer
// Echoes link bytes, judges received lines and sends bring-up commands.
// ----------------------------------------------------------------------------
// Each accepted item passes through a queue slot and the back end's job register
// before its first result reaches the output register.
// Throughput: the back end emits one result per cycle while the result side is ready,
// and passes through its idle state to load each job; a four-job queue lets
// the input keep taking items meanwhile. Items with no result take no back-end time.
// Reset clears the step, the line length, the queue and the output valid flag.
module at_command_link_sequencer
  import acls_pkg::*;
#(
  parameter int LINE_SPAN = LINE_SPAN_DEFAULT
) (
  input  wire           clk,
  input  wire           rst,
  acls_item_if.sink     item,
  acls_result_if.source result
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  acls_job_t push_job;
  acls_job_t pop_job;

  acls_front #(
    .LINE_SPAN(LINE_SPAN)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .item(item),
    .full(q_full),
    .push(q_push),
    .job (push_job)
  );

  acls_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  acls_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .pop_job(pop_job),
    .pop    (q_pop),
    .result (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_rotate_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind) |-> (result.last && result.tx_byte == 8'h00))
    else $error("rotate command not final or carries a byte");

  a_byte_no_rotate: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.kind) |-> !result.rotate_right)
    else $error("link byte carries a rotate direction");

endmodule
`default_nettype wire

/* src/acls_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer front end
// Accepts items, tracks the line and the bring-up step, and queues jobs.
// ----------------------------------------------------------------------------
module acls_front
  import acls_pkg::*;
#(
  parameter int LINE_SPAN = LINE_SPAN_DEFAULT
) (
  input  wire       clk,
  input  wire       rst,
  acls_item_if.sink item,
  input  wire       full,
  output logic      push,
  output acls_job_t job
);

  localparam int LEN_W = $clog2(LINE_SPAN);
  localparam logic [3:0] LAST_ADVANCE = 4'd8;

  logic [3:0]       step;
  logic [3:0]       step_next;
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] line_length_next;
  logic [7:0]       line_head [HEAD_DEPTH];
  logic             accept;
  logic             head_write;
  logic             is_ok;
  logic             is_right;
  logic             is_left;

  assign item.ready = !full;
  assign accept     = item.valid && item.ready;

  assign is_ok = (line_length == LEN_W'(2)) && (line_head[0] == 8'h4F)
              && (line_head[1] == 8'h4B);
  assign is_right = (line_length == LEN_W'(5)) && (line_head[0] == 8'h52)
                 && (line_head[1] == 8'h69) && (line_head[2] == 8'h67)
                 && (line_head[3] == 8'h68) && (line_head[4] == 8'h74);
  assign is_left = (line_length == LEN_W'(4)) && (line_head[0] == 8'h4C)
                && (line_head[1] == 8'h65) && (line_head[2] == 8'h66)
                && (line_head[3] == 8'h74);

  always_comb begin
    push             = 1'b0;
    job.echo         = 1'b0;
    job.echo_byte    = item.rx_byte;
    job.act          = ACT_NONE;
    job.row          = step[ROW_W-1:0];
    step_next        = step;
    line_length_next = line_length;
    head_write       = 1'b0;
    if (item.operation) begin
      push    = accept && (step < 4'(CMD_ROWS));
      job.act = ACT_CMD;
    end else if (item.rx_byte == BYTE_SKIP) begin
      push = 1'b0;
    end else if (item.rx_byte == BYTE_CR) begin
      push             = accept;
      job.echo         = 1'b1;
      line_length_next = '0;
      if (is_ok) begin
        if (step <= LAST_ADVANCE) begin
          step_next = step + 4'd1;
          job.row   = step_next[ROW_W-1:0];
          if (step_next < 4'(CMD_ROWS)) begin
            job.act = ACT_CMD;
          end
        end
      end else if (is_right) begin
        job.act = ACT_ROT_RIGHT;
      end else if (is_left) begin
        job.act = ACT_ROT_LEFT;
      end
    end else begin
      push       = accept;
      job.echo   = 1'b1;
      head_write = line_length < LEN_W'(HEAD_DEPTH);
      if (line_length == LEN_W'(LINE_SPAN - 1)) begin
        line_length_next = '0;
      end else begin
        line_length_next = line_length + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      line_length <= '0;
    end else if (accept) begin
      step        <= step_next;
      line_length <= line_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && head_write) begin
      line_head[line_length[HEAD_IDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule
`default_nettype wire

/* src/acls_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer job queue
// Small FIFO of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module acls_queue
  import acls_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  wire acls_job_t push_job,
  output logic           full,
  input  wire            pop,
  output acls_job_t      pop_job,
  output logic           empty
);

  acls_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

/* src/acls_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AT command link sequencer back end
// Turns each job into its echo, command bytes or rotate command.
// ----------------------------------------------------------------------------
module acls_back
  import acls_pkg::*;
(
  input  wire            clk,
  input  wire            rst,
  input  wire            empty,
  input  wire acls_job_t pop_job,
  output logic           pop,
  acls_result_if.source  result
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t           state;
  acls_job_t        cur;
  logic             echo_pend;
  logic [IDX_W-1:0] idx;
  acls_result_t     out_reg;
  logic             out_valid;
  acls_result_t     nxt;
  logic             advance;

  assign pop     = (state == S_IDLE);
  assign advance = (state == S_RUN) && (!out_valid || result.ready);

  assign result.valid        = out_valid;
  assign result.kind         = out_reg.kind;
  assign result.tx_byte      = out_reg.tx_byte;
  assign result.rotate_right = out_reg.rotate_right;
  assign result.last         = out_reg.last;

  always_comb begin
    nxt = '0;
    if (echo_pend) begin
      nxt.tx_byte = cur.echo_byte;
      nxt.last    = (cur.act == ACT_NONE);
    end else begin
      case (cur.act)
        ACT_CMD: begin
          nxt.tx_byte = cmd_byte(cur.row, idx);
          nxt.last    = (idx == cmd_len(cur.row) - 6'd1);
        end
        ACT_ROT_RIGHT: begin
          nxt.kind         = 1'b1;
          nxt.rotate_right = 1'b1;
          nxt.last         = 1'b1;
        end
        ACT_ROT_LEFT: begin
          nxt.kind = 1'b1;
          nxt.last = 1'b1;
        end
        default: begin
          nxt.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      echo_pend <= 1'b0;
      idx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_valid && result.ready) begin
            out_valid <= 1'b0;
          end
          if (!empty) begin
            cur       <= pop_job;
            echo_pend <= pop_job.echo;
            idx       <= '0;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          if (advance) begin
            out_reg   <= nxt;
            out_valid <= 1'b1;
            echo_pend <= 1'b0;
            if (!echo_pend && cur.act == ACT_CMD) begin
              idx <= idx + 6'd1;
            end
            if (nxt.last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/tb_at_command_link_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT command link sequencer testbench
// Sends link bytes and resend ticks through the item channel and checks every
// transfer on the result channel against a local prediction of echoes,
// bring-up commands and rotate commands. Both channels idle in random bursts,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_at_command_link_sequencer
  import acls_pkg::*;
();

  localparam bit         OP_BYTE           = 1'b0;
  localparam bit         OP_TICK           = 1'b1;
  localparam bit         KIND_TX           = 1'b0;
  localparam bit         KIND_ROTATE       = 1'b1;
  localparam logic [7:0] BYTE_LF           = 8'h0A;
  localparam int         LAST_ADVANCE_STEP = 8;
  localparam int         ROM_SPAN          = 43;
  localparam int         RANDOM_ITEMS      = 136;
  localparam int         HOLD_OFF_CYCLES   = 400;
  localparam int         DRAIN_CYCLES      = 16;
  localparam int         CYCLE_LIMIT       = 800000;

  class link_scoreboard;
    logic [7:0]   rom_text [CMD_ROWS][ROM_SPAN];
    int           rom_len [CMD_ROWS];
    logic [3:0]   step;
    int           line_len;
    logic [7:0]   head [HEAD_DEPTH];
    acls_result_t batch [$];
    acls_result_t awaited [$];
    int           mismatches;

    function new();
      step       = 4'd0;
      line_len   = 0;
      mismatches = 0;
      foreach (head[i]) head[i] = 8'h00;
      load_text(0, "AT");
      load_text(1, "AT+CWMODE=3");
      load_text(2, "AT+CWQAP");
      load_hex(3, {80'h41542B43574A41503D22, 80'h7373656D656E6B6F6666,
                   80'h2D70726976617465222C, 80'h2273656D656E6B6F6666,
                   24'h220D0A}, 43);
      load_hex(4, {80'h41542B43495053544152, 80'h543D22544350222C2231,
                   80'h39322E3136382E313030, 72'h2E3130222C38300D0A}, 39);
      load_text(5, "AT+CIPSEND=21");
      load_text(6, "GET /state HTTP/1.1");
    endfunction

    function void load_text(int row, string s);
      for (int i = 0; i < s.len(); i++) rom_text[row][i] = s[i];
      rom_text[row][s.len()]     = BYTE_CR;
      rom_text[row][s.len() + 1] = BYTE_LF;
      rom_len[row]               = s.len() + 2;
    endfunction

    function void load_hex(int row, logic [8*ROM_SPAN-1:0] v, int n);
      for (int i = 0; i < n; i++) rom_text[row][i] = v[(n - 1 - i) * 8 +: 8];
      rom_len[row] = n;
    endfunction

    function void add(bit k, logic [7:0] b, bit r);
      acls_result_t e;
      e.kind         = k;
      e.tx_byte      = b;
      e.rotate_right = r;
      e.last         = 1'b0;
      batch.push_back(e);
    endfunction

    function void add_command();
      if (step < CMD_ROWS) begin
        for (int i = 0; i < rom_len[step]; i++) add(KIND_TX, rom_text[step][i], 1'b0);
      end
    endfunction

    function bit line_matches(string w);
      if (line_len != w.len() || w.len() > HEAD_DEPTH) return 1'b0;
      for (int i = 0; i < w.len(); i++) begin
        if (head[i] != w[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(bit op, logic [7:0] b);
      batch.delete();
      if (op == OP_TICK) begin
        add_command();
      end else if (b == BYTE_SKIP) begin
        return;
      end else if (b == BYTE_CR) begin
        add(KIND_TX, b, 1'b0);
        if (line_matches("OK")) begin
          if (step <= LAST_ADVANCE_STEP) begin
            step = step + 4'd1;
            add_command();
          end
        end else if (line_matches("Right")) begin
          add(KIND_ROTATE, 8'h00, 1'b1);
        end else if (line_matches("Left")) begin
          add(KIND_ROTATE, 8'h00, 1'b0);
        end
        line_len = 0;
      end else begin
        add(KIND_TX, b, 1'b0);
        if (line_len < HEAD_DEPTH) head[line_len] = b;
        line_len = (line_len + 1) % LINE_SPAN_DEFAULT;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) awaited.push_back(batch[i]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_reply(acls_result_t got);
      acls_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected transfer kind=%0d tx_byte=%02h rotate_right=%0d last=%0d",
                         got.kind, got.tx_byte, got.rotate_right, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
      if (got.rotate_right !== want.rotate_right)
        report($sformatf("rotate_right %0d, expected %0d", got.rotate_right, want.rotate_right));
      if (got.last !== want.last)
        report($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  acls_item_if   item_if ();
  acls_result_if result_if ();

  link_scoreboard board;
  int             cycles       = 0;
  int             counted      = 0;
  bit             calm         = 1'b0;
  bit             hold_off_req = 1'b0;

  at_command_link_sequencer uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    acls_result_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got.kind         = result_if.kind;
      got.tx_byte      = result_if.tx_byte;
      got.rotate_right = result_if.rotate_right;
      got.last         = result_if.last;
      board.check_reply(got);
    end
  end

  initial begin : result_side
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      result_if.ready <= 1'b1;
    end
  end

  task automatic send_item(bit op, logic [7:0] b);
    item_if.valid     <= 1'b1;
    item_if.operation <= op;
    item_if.rx_byte   <= b;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    board.note_item(op, b);
    if (op == OP_TICK || b != BYTE_SKIP) counted++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
    send_item(OP_BYTE, BYTE_CR);
  endtask

  initial begin : stimulus
    int    pick;
    int    n;
    int    start;
    int    target;
    bit    held;
    bit    wrapped;
    string word;
    logic [7:0] b;

    board = new();
    held    = 1'b0;
    wrapped = 1'b0;
    rst               <= 1'b1;
    item_if.valid     <= 1'b0;
    item_if.operation <= OP_BYTE;
    item_if.rx_byte   <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: commands, rotates, a zero byte, a dropped byte inside a word.
    send_item(OP_TICK, 8'hFF);
    send_line("Right");
    send_line("Left");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, BYTE_CR);
    send_item(OP_BYTE, "O");
    send_item(OP_BYTE, BYTE_SKIP);
    send_item(OP_BYTE, "K");
    send_item(OP_BYTE, BYTE_CR);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, "O");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, BYTE_CR);

    start  = counted;
    target = counted + RANDOM_ITEMS;
    while (counted < target) begin
      if (!held && counted >= start + 20) begin
        held         = 1'b1;
        hold_off_req = 1'b1;
      end
      if (counted >= target - 40) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (!wrapped && counted >= start + 40) begin
        // A line longer than the count span wraps and gathers afresh.
        wrapped = 1'b1;
        for (int i = 0; i < LINE_SPAN_DEFAULT; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == BYTE_CR || b == BYTE_SKIP) b = 8'h20;
          send_item(OP_BYTE, b);
        end
        case ($urandom_range(0, 2))
          0:       send_line("OK");
          1:       send_line("Right");
          default: send_line("Left");
        endcase
      end else if (pick < 22) begin
        send_line("OK");
      end else if (pick < 42) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 56) begin
        if ($urandom_range(0, 1) == 1) begin
          send_line("Right");
        end else begin
          send_line("Left");
        end
      end else if (pick < 66) begin
        case ($urandom_range(0, 6))
          0:       word = "Righ";
          1:       word = "Lefts";
          2:       word = "ok";
          3:       word = "OKK";
          4:       word = "RIGHT";
          5:       word = "K";
          default: word = "";
        endcase
        send_line(word);
      end else if (pick < 86) begin
        n = $urandom_range(0, 7);
        repeat (n) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        send_item(OP_BYTE, BYTE_CR);
      end else begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) b = BYTE_SKIP;
        send_item(OP_BYTE, b);
      end
    end
    item_if.valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/acls_pkg.sv
src/acls_if.sv
src/acls_front.sv
src/acls_queue.sv
src/acls_back.sv
src/at_command_link_sequencer.sv
verif/tb_at_command_link_sequencer.sv
